// ===== rtl/msb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multi-pattern byte scanner.
// Used by every module of the block; depends on nothing.
package msb_pkg;

	localparam int PAT_COUNT   = 4;
	localparam int SLOT_W      = $clog2(PAT_COUNT);
	localparam int PAT_BYTES   = 128;
	localparam int IDX_W       = $clog2(PAT_BYTES);
	localparam int LEN_W       = $clog2(PAT_BYTES + 1);
	localparam int OFF_W       = 32;
	localparam int OUT_OFF_W   = 32;
	localparam int GROUP_SIZE  = 16;
	localparam int GROUP_COUNT = PAT_BYTES / GROUP_SIZE;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W      = 4;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 40;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SCAN = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [PAT_COUNT-1:0][7:0] pat_bytes_t;
	typedef logic [PAT_COUNT-1:0][LEN_W-1:0] len_set_t;
	typedef logic [PAT_COUNT-1:0][OFF_W-1:0] off_set_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic                 scan;
		logic [PAT_COUNT-1:0] rot;
		logic                 load;
		logic [SLOT_W-1:0]    load_slot;
		logic [IDX_W-1:0]     load_cell;
		byte_t                load_data;
		len_set_t             len;
	} cell_ctrl_t;

	// Per-beat information that travels alongside the compare bits.
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [PAT_COUNT-1:0] en;
		off_set_t             off;
	} stage_info_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_W-1:0]    pattern;
		logic [OUT_OFF_W-1:0] offset;
	} result_t;

endpackage

// ===== rtl/msb_cell.sv =====
`timescale 1ns / 1ps
// One position of the scanning chain: a recent buffer byte, one stored byte per
// pattern and the registered compare bits. Depends on msb_pkg.
module msb_cell (
	input  logic                         clk,
	input  logic [msb_pkg::IDX_W-1:0]    cell_index,
	input  msb_pkg::cell_ctrl_t          ctrl,
	input  msb_pkg::byte_t               recent_in,
	output msb_pkg::byte_t               recent_out,
	input  msb_pkg::pat_bytes_t          pat_in,
	output msb_pkg::pat_bytes_t          pat_out,
	output logic [msb_pkg::PAT_COUNT-1:0] eq_out
);
	import msb_pkg::*;

	byte_t                recent_q;
	pat_bytes_t           pat_q;
	logic [PAT_COUNT-1:0] eq_s1;
	logic [PAT_COUNT-1:0] eq_next;

	// A position beyond a pattern's length never blocks its match.
	always_comb begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			eq_next[k] = (recent_in == pat_q[k]) ||
				!({1'b0, cell_index} < ctrl.len[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan) begin
			recent_q <= recent_in;
			eq_s1    <= eq_next;
		end
		for (int k = 0; k < PAT_COUNT; k++) begin
			if (ctrl.rot[k]) begin
				pat_q[k] <= pat_in[k];
			end else if (ctrl.load && ctrl.load_slot == SLOT_W'(k) &&
					ctrl.load_cell == cell_index) begin
				pat_q[k] <= ctrl.load_data;
			end
		end
	end

	assign recent_out = recent_q;
	assign pat_out    = pat_q;
	assign eq_out     = eq_s1;

endmodule

// ===== rtl/msb_hit_tracker.sv =====
`timescale 1ns / 1ps
// Reduces the chain's compare bits in two steps, the first of them registered, keeps
// the first hit of each pattern and forms the buffer result. Depends on msb_pkg.
module msb_hit_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  msb_pkg::stage_info_t        info_in,
	input  logic [msb_pkg::PAT_COUNT-1:0][msb_pkg::PAT_BYTES-1:0] eq_bits,
	output logic                        last_pending,
	output logic                        push,
	output msb_pkg::result_t            result
);
	import msb_pkg::*;

	logic [PAT_COUNT-1:0][GROUP_COUNT-1:0] grp_s2;
	stage_info_t                           info_s2;
	logic [PAT_COUNT-1:0]                  hit_q;
	off_set_t                              off_q;
	logic [PAT_COUNT-1:0]                  full;
	logic [PAT_COUNT-1:0]                  hit_all;
	off_set_t                              off_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s2 <= '0;
		end else begin
			info_s2.valid <= info_in.valid;
			info_s2.last  <= info_in.valid && info_in.last;
			info_s2.en    <= info_in.en;
			info_s2.off   <= info_in.off;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			for (int g = 0; g < GROUP_COUNT; g++) begin
				grp_s2[k][g] <= &eq_bits[k][g*GROUP_SIZE +: GROUP_SIZE];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			full[k]    = info_s2.en[k] && (&grp_s2[k]);
			hit_all[k] = hit_q[k] || full[k];
			off_sel[k] = hit_q[k] ? off_q[k] : info_s2.off[k];
		end
		result = '0;
		for (int k = PAT_COUNT - 1; k >= 0; k--) begin
			if (hit_all[k]) begin
				result.found   = 1'b1;
				result.pattern = SLOT_W'(k);
				result.offset  = OUT_OFF_W'(off_sel[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (info_s2.valid) begin
			if (info_s2.last) begin
				hit_q <= '0;
			end else begin
				hit_q <= hit_all;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			if (info_s2.valid && !hit_q[k]) begin
				off_q[k] <= info_s2.off[k];
			end
		end
	end

	assign push         = info_s2.valid && info_s2.last;
	assign last_pending = info_s2.last;

endmodule

// ===== rtl/msb_result_fifo.sv =====
`timescale 1ns / 1ps
// Small queue that holds finished results until the receiver takes them.
// Depends on msb_pkg.
module msb_result_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  msb_pkg::result_t                 push_data,
	input  logic                             pop,
	output logic                             not_empty,
	output msb_pkg::result_t                 head,
	output logic [msb_pkg::FIFO_CNT_W-1:0]   count
);
	import msb_pkg::*;

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];
	assign count     = count_q;

endmodule

// ===== rtl/multi_pattern_byte_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the multi-pattern byte scanner: configuration registers, input
// decode, the chain of msb_cell, msb_hit_tracker and msb_result_fifo. Uses msb_pkg.
//
// Usage. Input beats arrive on the s_ group. s_tuser selects the command: a load
// beat writes one pattern byte, a scan beat feeds one buffer byte. s_tlast marks
// the last scan byte of a buffer. Each pattern's length sits in an APB register;
// a length of zero disables the pattern. Exactly one result beat leaves on the
// m_ group for every scan beat that carries s_tlast.
// Throughput is one beat per cycle while s_tready is high, loads and scans alike.
// Between the edge that accepts a buffer's last byte and its result being presented,
// the compare bits are registered in the cells, reduced in the tracker and written
// into the results queue. Writing a length realigns that pattern's bytes along the
// chain by rotating them one cell per cycle, and s_tready is low while any pattern
// is rotating. The results queue holds four beats. Apart from realignment, s_tready
// drops only when the queued and in-flight results would fill it, so a stalled
// receiver never loses a result and s_tready never depends combinationally on
// m_tready. After reset all lengths are zero, the per-buffer state is clear and the
// queue is empty; the pattern bytes themselves hold no defined value until loaded.
module multi_pattern_byte_scanner (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [msb_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Input beats
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] pattern_slot, [8:2] byte_position, [16:9] data_byte, rest zero
	input  logic [msb_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] cmd
	input  logic                               s_tuser,
	input  logic                               s_tlast,
	// Result beats
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] matched_pattern, [33:2] match_offset, rest zero
	output logic [msb_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] match_found
	output logic                               m_tuser
);
	import msb_pkg::*;

	len_set_t                len_q;
	logic [PAT_COUNT-1:0][IDX_W-1:0] align_q;
	logic [PAT_COUNT-1:0]    rot;
	logic [OFF_W-1:0]        bytes_seen_q;
	stage_info_t             info_s1;
	cell_ctrl_t              ctrl;

	logic                    s_fire;
	logic                    scan_fire;
	logic                    load_fire;
	logic [SLOT_W-1:0]       in_slot;
	logic [IDX_W-1:0]        in_pos;
	byte_t                   in_byte;
	logic [SLOT_W-1:0]       cfg_idx;
	logic                    cfg_wr;
	byte_t                   cfg_len;

	byte_t                   recent [PAT_BYTES];
	pat_bytes_t              pat [PAT_BYTES];
	logic [PAT_COUNT-1:0]    cell_eq [PAT_BYTES];
	logic [PAT_COUNT-1:0][PAT_BYTES-1:0] eq_bits;

	logic                    last_s2;
	logic                    push;
	result_t                 push_data;
	result_t                 head;
	logic [FIFO_CNT_W-1:0]   fifo_count;
	logic [FIFO_CNT_W-1:0]   outstanding;

	// Configuration registers. Lengths above the chain length are clamped.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_len = (pwdata[7:0] > 8'(PAT_BYTES)) ? 8'(PAT_BYTES) : pwdata[7:0];
	assign prdata  = {{(32 - LEN_W){1'b0}}, len_q[cfg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_wr) begin
			len_q[cfg_idx] <= LEN_W'(cfg_len);
		end
	end

	// Each pattern is held so that cell j carries pattern byte (L - 1 - j) mod
	// the chain length, L being the alignment. One rotation step along the chain
	// raises the alignment by one, so a new length is reached by rotating until
	// the alignment equals it.
	always_comb begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			rot[k] = (align_q[k] != len_q[k][IDX_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= '0;
		end else begin
			for (int k = 0; k < PAT_COUNT; k++) begin
				if (rot[k]) begin
					align_q[k] <= align_q[k] + IDX_W'(1);
				end
			end
		end
	end

	// Input decode and flow control.
	assign in_slot     = s_tdata[SLOT_W-1:0];
	assign in_pos      = s_tdata[SLOT_W +: IDX_W];
	assign in_byte     = s_tdata[SLOT_W + IDX_W +: 8];
	assign outstanding = fifo_count + FIFO_CNT_W'(info_s1.valid && info_s1.last)
		+ FIFO_CNT_W'(last_s2);
	assign s_tready    = !(|rot) && (outstanding < FIFO_CNT_W'(FIFO_DEPTH));
	assign s_fire      = s_tvalid && s_tready;
	assign scan_fire   = s_fire && (s_tuser == CMD_SCAN);
	assign load_fire   = s_fire && (s_tuser == CMD_LOAD);

	always_comb begin
		ctrl.scan      = scan_fire;
		ctrl.rot       = rot;
		ctrl.load      = load_fire;
		ctrl.load_slot = in_slot;
		ctrl.load_cell = align_q[in_slot] - in_pos - IDX_W'(1);
		ctrl.load_data = in_byte;
		ctrl.len       = len_q;
	end

	// Buffer position counter; it saturates and restarts after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
		end else if (scan_fire) begin
			if (s_tlast) begin
				bytes_seen_q <= '0;
			end else if (bytes_seen_q != '1) begin
				bytes_seen_q <= bytes_seen_q + OFF_W'(1);
			end
		end
	end

	// Beat information registered alongside the cells' compare bits. A pattern
	// may only complete once at least its length has been scanned in this buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s1 <= '0;
		end else begin
			info_s1.valid <= scan_fire;
			if (scan_fire) begin
				info_s1.last <= s_tlast;
				for (int k = 0; k < PAT_COUNT; k++) begin
					info_s1.en[k]  <= (len_q[k] != '0) &&
						((OFF_W + 1)'(bytes_seen_q) + (OFF_W + 1)'(1) >=
						(OFF_W + 1)'(len_q[k]));
					info_s1.off[k] <= bytes_seen_q + OFF_W'(1) - OFF_W'(len_q[k]);
				end
			end
		end
	end

	// The chain: buffer bytes move one cell further on each scan beat, pattern
	// bytes rotate around the ring while a pattern is being realigned.
	for (genvar j = 0; j < PAT_BYTES; j++) begin : g_cell
		msb_cell u_cell (
			.clk        (clk),
			.cell_index (IDX_W'(j)),
			.ctrl       (ctrl),
			.recent_in  ((j == 0) ? in_byte : recent[(j + PAT_BYTES - 1) % PAT_BYTES]),
			.recent_out (recent[j]),
			.pat_in     (pat[(j + PAT_BYTES - 1) % PAT_BYTES]),
			.pat_out    (pat[j]),
			.eq_out     (cell_eq[j])
		);
		for (genvar k = 0; k < PAT_COUNT; k++) begin : g_eq
			assign eq_bits[k][j] = cell_eq[j][k];
		end
	end

	msb_hit_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.info_in      (info_s1),
		.eq_bits      (eq_bits),
		.last_pending (last_s2),
		.push         (push),
		.result       (push_data)
	);

	msb_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.head      (head),
		.count     (fifo_count)
	);

	assign m_tdata = {{(OUT_DATA_W - OUT_OFF_W - SLOT_W){1'b0}}, head.offset, head.pattern};
	assign m_tuser = head.found;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_pattern_byte_scanner: directed and random
// buffers checked against an in-bench model of the search. Depends on msb_pkg.
module tb_top;

	import msb_pkg::*;

	// Cycles of quiet (no beat, no register access) before the run is declared hung.
	localparam int QUIET_LIMIT  = 4000;
	// Cycles allowed after the last expected result before a register write or the end.
	localparam int DRAIN_CYCLES = 8;
	// Byte stride between length registers on the APB port.
	localparam int REG_STRIDE   = 4;

	typedef enum int {
		RDY_ALWAYS,
		RDY_MASKED,
		RDY_RANDOM,
		RDY_SPARSE
	} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	// [1:0] pattern_slot, [8:2] byte_position, [16:9] data_byte, rest zero
	logic [IN_DATA_W-1:0]  s_tdata;
	// [0] cmd
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	// [1:0] matched_pattern, [33:2] match_offset, rest zero
	logic [OUT_DATA_W-1:0] m_tdata;
	// [0] match_found
	logic                  m_tuser;

	multi_pattern_byte_scanner u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Search model. It mirrors the block's view of the world: the stored
	// patterns, the window of recently scanned bytes, the byte count of the
	// current buffer and the earliest hit of every pattern.
	// ------------------------------------------------------------------
	byte_t             pat_mem [PAT_COUNT][PAT_BYTES];
	byte_t             recent [PAT_BYTES];
	logic [OFF_W-1:0]  bytes_in_buffer;
	bit                pat_hit [PAT_COUNT];
	logic [OFF_W-1:0]  first_hit [PAT_COUNT];
	int                pat_len [PAT_COUNT];

	// Results that the block owes us, oldest first.
	result_t           pending_results [$];
	int                mismatches;

	// Sender burst state.
	int                burst_left;

	// A length above the store depth behaves as the full depth.
	function automatic int clamp_len(input int value);
		int v;
		v = value & 8'hFF;
		return (v > PAT_BYTES) ? PAT_BYTES : v;
	endfunction

	function automatic void clear_buffer_model();
		bytes_in_buffer = '0;
		for (int k = 0; k < PAT_COUNT; k++) begin
			pat_hit[k]   = 1'b0;
			first_hit[k] = '0;
		end
	endfunction

	// Applies one accepted input beat to the model and queues any result it causes.
	function automatic void track_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
			input logic [IDX_W-1:0] bpos, input byte_t data, input logic last);
		result_t         res;
		longint unsigned here;
		int              len;
		bit              same;
		if (cmd == CMD_LOAD) begin
			// The end flag means nothing on a load.
			pat_mem[slot][bpos] = data;
			return;
		end
		here = bytes_in_buffer;
		for (int i = PAT_BYTES - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = data;
		for (int k = 0; k < PAT_COUNT; k++) begin
			len = pat_len[k];
			// A pattern longer than the bytes seen so far in this buffer cannot match,
			// and only the earliest hit of each pattern is kept.
			if (len == 0 || pat_hit[k] || here + 1 < len)
				continue;
			same = 1'b1;
			for (int i = 0; i < len; i++)
				if (pat_mem[k][i] != recent[len-1-i])
					same = 1'b0;
			if (same) begin
				pat_hit[k]   = 1'b1;
				first_hit[k] = OFF_W'(here + 1 - len);
			end
		end
		// The byte counter sticks at its maximum.
		if (bytes_in_buffer != '1)
			bytes_in_buffer++;
		if (!last)
			return;
		res = '0;
		for (int k = 0; k < PAT_COUNT; k++) begin
			if (pat_hit[k]) begin
				res.found   = 1'b1;
				res.pattern = SLOT_W'(k);
				res.offset  = first_hit[k];
				break;
			end
		end
		pending_results.push_back(res);
		clear_buffer_model();
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Sends one input beat. The sender works in bursts; between bursts it drops
	// tvalid for a random gap, and about a quarter of the bursts follow on with no
	// gap at all. tvalid is left high after the beat so back-to-back beats never
	// see it lowered and raised in the same step.
	task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
			input logic [IDX_W-1:0] bpos, input byte_t data, input logic last);
		int                   gap;
		logic [IN_DATA_W-1:0] word;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word       = '0;
		word[1:0]  = slot;
		word[8:2]  = bpos;
		word[16:9] = data;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tlast  <= last;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		track_beat(cmd, slot, bpos, data, last);
	endtask

	// Scans a whole buffer; the final byte carries the end flag. The ignored
	// slot and position fields get random values.
	task automatic send_buffer(input byte_t bytes [$]);
		for (int i = 0; i < bytes.size(); i++)
			send_beat(CMD_SCAN, SLOT_W'($urandom), IDX_W'($urandom), bytes[i],
				i == bytes.size() - 1);
	endtask

	// Stops sending, lets every owed result arrive, then lets the pipeline settle,
	// since a scan byte without the end flag leaves nothing behind to wait for.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one length register over APB: a setup cycle, then an access cycle
	// that completes at the edge where pready is seen high.
	task automatic write_length(input int slot, input int value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(slot * REG_STRIDE);
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		pat_len[slot] = clamp_len(value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random buffers for one setting of the four lengths. Most buffers carry
	// copies of enabled patterns at random places, some of them with one bit
	// flipped, over random background; now and then a stray load beat is mixed
	// in, with a random end flag. With the repetitive option the first bytes of
	// every pattern and the background come from a two-letter alphabet, which
	// gives overlapping and near-miss windows.
	task automatic run_random_buffers(input int len0, input int len1, input int len2,
			input int len3, input int budget, input bit repetitive);
		int    lens [PAT_COUNT];
		int    sent;
		int    n;
		int    k;
		int    span;
		int    start;
		int    longest;
		byte_t scan_q [$];
		lens = '{len0, len1, len2, len3};
		sent = 0;
		if (repetitive) begin
			for (int s = 0; s < PAT_COUNT; s++)
				for (int i = 0; i < 8; i++) begin
					send_beat(CMD_LOAD, SLOT_W'(s), IDX_W'(i),
						$urandom_range(0, 1) ? 8'hAA : 8'h55, 1'b0);
					sent++;
				end
		end
		for (int s = 0; s < PAT_COUNT; s++)
			write_length(s, lens[s]);
		longest = 0;
		for (int s = 0; s < PAT_COUNT; s++)
			if (clamp_len(lens[s]) > longest)
				longest = clamp_len(lens[s]);
		while (sent < budget) begin
			case ($urandom_range(0, 7))
				0:       n = $urandom_range(1, 3);
				1, 2, 3: n = (longest > 0) ? $urandom_range(longest, longest + 16)
					: $urandom_range(1, 24);
				default: n = $urandom_range(1, (longest + 16 > 24) ? longest + 16 : 24);
			endcase
			scan_q.delete();
			for (int i = 0; i < n; i++)
				if (repetitive)
					scan_q.push_back($urandom_range(0, 1) ? 8'hAA : 8'h55);
				else
					scan_q.push_back(byte_t'($urandom));
			repeat ($urandom_range(0, 3)) begin
				k    = $urandom_range(0, PAT_COUNT - 1);
				span = clamp_len(lens[k]);
				if (span == 0 || span > n)
					continue;
				start = $urandom_range(0, n - span);
				for (int i = 0; i < span; i++)
					scan_q[start+i] = pat_mem[k][i];
				if ($urandom_range(0, 4) == 0)
					scan_q[start + $urandom_range(0, span - 1)] ^= byte_t'(1 << $urandom_range(0, 7));
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					send_beat(CMD_LOAD, SLOT_W'($urandom), IDX_W'($urandom),
						byte_t'($urandom), 1'($urandom));
					sent++;
				end
				send_beat(CMD_SCAN, SLOT_W'($urandom), IDX_W'($urandom), scan_q[i],
					i == n - 1);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Straight after reset every length is zero, so no buffer can match. A load
	// carrying the end flag must not produce a result. The load writes the
	// extreme corner of the store with all ones.
	task automatic test_unconfigured();
		send_buffer('{8'h00});
		send_beat(CMD_LOAD, SLOT_W'(PAT_COUNT - 1), IDX_W'(PAT_BYTES - 1), 8'hFF, 1'b1);
		send_buffer('{8'hFF, 8'h80, 8'h7F});
	endtask

	// Fills every byte of every pattern, so no later match test reads a byte
	// that was never written. The first byte of pattern 0 is all zeros.
	task automatic test_pattern_load();
		for (int s = 0; s < PAT_COUNT; s++)
			for (int i = 0; i < PAT_BYTES; i++)
				send_beat(CMD_LOAD, SLOT_W'(s), IDX_W'(i),
					(s == 0 && i == 0) ? 8'h00 : byte_t'($urandom), 1'b0);
	endtask

	// Hand-built buffers from the stored patterns: a one-byte hit at offset zero,
	// two patterns in one buffer where the lower number wins despite its later
	// offset, a pattern split over two buffers which must not match, and a length
	// write in the middle of a buffer which must keep the hit already recorded.
	task automatic test_directed_matches();
		write_length(0, 1);
		write_length(1, 3);
		write_length(2, 2);
		write_length(3, 0);
		send_buffer('{pat_mem[0][0]});
		send_buffer('{pat_mem[2][0], pat_mem[2][1], pat_mem[1][0], pat_mem[1][1],
			pat_mem[1][2]});
		send_buffer('{pat_mem[1][0], pat_mem[1][1]});
		send_buffer('{pat_mem[1][2]});
		send_beat(CMD_SCAN, '0, '0, pat_mem[0][0], 1'b0);
		write_length(0, 0);
		send_beat(CMD_SCAN, '0, '0, ~pat_mem[0][0], 1'b1);
	endtask

	task automatic test_short_patterns();
		run_random_buffers(1, 2, 3, 4, 250, 1'b0);
	endtask

	// Full-depth patterns; two registers hold values above the depth and must
	// behave as the full depth.
	task automatic test_longest_patterns();
		run_random_buffers(PAT_BYTES, 255, PAT_BYTES + 1, 0, 400, 1'b0);
	endtask

	task automatic test_disabled_patterns();
		run_random_buffers(0, 0, 0, 0, 80, 1'b0);
	endtask

	task automatic test_repetitive_patterns();
		run_random_buffers($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
			$urandom_range(1, 8), 300, 1'b1);
	endtask

	// Mostly short lengths, some disabled and the odd long or out-of-range one.
	task automatic test_mixed_lengths();
		int lens [PAT_COUNT];
		int r;
		for (int s = 0; s < PAT_COUNT; s++) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				lens[s] = 0;
			else if (r < 9)
				lens[s] = $urandom_range(1, 12);
			else
				lens[s] = $urandom_range(13, 255);
		end
		run_random_buffers(lens[0], lens[1], lens[2], lens[3], 350, 1'b0);
	endtask

	initial begin
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_LOAD;
		s_tlast  <= 1'b0;
		burst_left = 0;
		mismatches = 0;
		for (int i = 0; i < PAT_BYTES; i++)
			recent[i] = '0;
		for (int k = 0; k < PAT_COUNT; k++)
			pat_len[k] = 0;
		clear_buffer_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unconfigured();
		test_pattern_load();
		test_directed_matches();
		test_short_patterns();
		test_longest_patterns();
		test_disabled_patterns();
		test_repetitive_patterns();
		test_mixed_lengths();

		// Drain: the watchdog catches a result that never comes.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("multi_pattern_byte_scanner regression: pass");
		else
			$display("multi_pattern_byte_scanner regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver. It keeps to one stall pattern for a random stretch, then picks
	// another: always ready, a repeating random eight-bit mask, random stalls, or ready
	// only when the step counter is a multiple of eight.
	// ------------------------------------------------------------------
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          ready_left = 0;
	int          ready_step = 0;
	logic [7:0]  ready_mask;

	initial m_tready = 1'b0;

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = $urandom_range(20, 200);
			ready_mask = 8'($urandom);
		end
		ready_left--;
		ready_step++;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_MASKED: m_tready <= ready_mask[ready_step % 8];
			RDY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			default:    m_tready <= (ready_step % 8 == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result checking. Each accepted result beat is held against the oldest
	// expected result, field by field.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field,
				want, got);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat, match_found", 0, m_tuser);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.found)
					report_mismatch("match_found", want.found, m_tuser);
				if (m_tdata[1:0] !== want.pattern)
					report_mismatch("matched_pattern", want.pattern, m_tdata[1:0]);
				if (m_tdata[33:2] !== want.offset)
					report_mismatch("match_offset", want.offset, m_tdata[33:2]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat or register access counts as progress.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("multi_pattern_byte_scanner regression: fail");
				$finish;
			end
		end
	end

endmodule

// ===== multi_pattern_byte_scanner.f =====
rtl/msb_pkg.sv
rtl/msb_cell.sv
rtl/msb_hit_tracker.sv
rtl/msb_result_fifo.sv
rtl/multi_pattern_byte_scanner.sv
tb/tb_top.sv
